>>> design/body_table_potential_energy_unit_defines.svh
// Assertion macros for the body table potential energy unit.
// No dependencies; included by the files that assert.
`ifndef BODY_TABLE_POTENTIAL_ENERGY_UNIT_DEFINES_SVH
`define BODY_TABLE_POTENTIAL_ENERGY_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// Asserts that antecedent implies consequent at the next edge.
`define BTPE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
// Asserts that antecedent implies consequent at the same edge.
`define BTPE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`else
`define BTPE_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`define BTPE_ASSERT_NOW(label, clk, rst_n, ante, cons)
`endif
`endif

>>> design/btpe_pkg.sv
// Package for the body table potential energy unit: codes and types.
// No dependencies.
package btpe_pkg;
  localparam logic [1:0] MODE_APPEND    = 2'd0;
  localparam logic [1:0] MODE_OVERWRITE = 2'd1;
  localparam logic [1:0] MODE_REMOVE    = 2'd2;
  localparam logic [1:0] MODE_QUERY     = 2'd3;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_INDEX = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  localparam logic CFG_COEFF = 1'b0;
  localparam logic CFG_SHIFT = 1'b1;

  // Operations of the shared serial unit.
  typedef enum logic [1:0] {
    OP_MUL  = 2'd0,
    OP_SQRT = 2'd1,
    OP_DIV  = 2'd2
  } alu_op_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_ctl_t;
endpackage

>>> design/btpe_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module btpe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

>>> design/btpe_alu.sv
// Shared serial arithmetic unit: shift-add multiply, bit-pair square root
// and restoring division, one bit per cycle. Uses btpe_pkg.
module btpe_alu (
  input  logic              clk,
  input  logic              rst_n,
  input  btpe_pkg::alu_ctl_t ctl,
  input  logic [95:0]       op_a,
  input  logic [63:0]       op_b,
  output logic [95:0]       res,
  output logic              done
);
  import btpe_pkg::*;

  alu_op_t      op_r, op_nxt;
  logic         busy_r, busy_nxt;
  logic [6:0]   cnt_r, cnt_nxt;
  logic [95:0]  acc_r, acc_nxt;   // product, quotient or root
  logic [95:0]  sh_r, sh_nxt;     // shifting operand
  logic [67:0]  rem_r, rem_nxt;   // partial remainder
  logic [63:0]  b_r, b_nxt;
  logic         done_r, done_nxt;
  logic [68:0]  trial;
  logic [64:0]  dtrial;

  always_comb begin
    op_nxt   = op_r;
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    sh_nxt   = sh_r;
    rem_nxt  = rem_r;
    b_nxt    = b_r;
    done_nxt = 1'b0;
    trial    = '0;
    dtrial   = '0;
    if (ctl.start) begin
      op_nxt   = ctl.op;
      busy_nxt = 1'b1;
      acc_nxt  = '0;
      rem_nxt  = '0;
      sh_nxt   = op_a;
      b_nxt    = op_b;
      case (ctl.op)
        OP_MUL:  cnt_nxt = 7'd64;
        OP_SQRT: cnt_nxt = 7'd34;
        OP_DIV:  cnt_nxt = 7'd96;
        default: cnt_nxt = 7'd1;
      endcase
    end else if (busy_r) begin
      case (op_r)
        OP_MUL: begin
          // 96 x 64 product kept to 96 bits; operands never exceed that.
          if (b_r[0]) begin
            acc_nxt = acc_r + sh_r;
          end
          sh_nxt = {sh_r[94:0], 1'b0};
          b_nxt  = {1'b0, b_r[63:1]};
        end
        OP_SQRT: begin
          // Radicand in sh_r[67:0], two bits per step.
          trial = {rem_r[66:0], sh_r[67:66]} - {33'd0, acc_r[33:0], 2'b01};
          if (!trial[68]) begin
            rem_nxt = trial[67:0];
            acc_nxt = {acc_r[94:0], 1'b1};
          end else begin
            rem_nxt = {rem_r[65:0], sh_r[67:66]};
            acc_nxt = {acc_r[94:0], 1'b0};
          end
          sh_nxt = {sh_r[93:0], 2'b00};
        end
        OP_DIV: begin
          dtrial = {rem_r[63:0], sh_r[95]} - {1'b0, b_r};
          if (!dtrial[64] || rem_r[64]) begin
            rem_nxt = {3'b000, dtrial};
            acc_nxt = {acc_r[94:0], 1'b1};
          end else begin
            rem_nxt = {rem_r[66:0], sh_r[95]};
            acc_nxt = {acc_r[94:0], 1'b0};
          end
          sh_nxt = {sh_r[94:0], 1'b0};
        end
        default: acc_nxt = acc_r;
      endcase
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
      op_r   <= OP_MUL;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
      op_r   <= op_nxt;
    end
    acc_r <= acc_nxt;
    sh_r  <= sh_nxt;
    rem_r <= rem_nxt;
    b_r   <= b_nxt;
  end

  assign res  = acc_r;
  assign done = done_r;
endmodule

>>> design/body_table_potential_energy_unit.sv
// Top level of the body table potential energy unit: sequencer, table
// memories and configuration. Uses btpe_pkg, btpe_ram and btpe_alu.
//
// The block holds a table of up to MAX_BODIES bodies. A beat on start is
// taken when busy is low. Append and overwrite give their result in the
// next cycle, and remove gives it once S_MOVE has copied the last row. A
// query walks every stored body through one shared serial unit that does
// the multiply (64 steps), the exact square root (34 steps) and the 96-bit
// division (96 steps) one bit per cycle. Each partner body takes three
// squares, the root, two multiplies and the division, each waited out in
// a wait state until it is done; a partner at zero distance skips the
// multiplies and the division. Every item gives exactly one result beat,
// shown on out_valid for a single cycle; the receiver cannot stall it. The
// table memories need no clearing after reset, since only written rows are
// read.
module body_table_potential_energy_unit #(
  parameter int MAX_BODIES = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_mode,
  input  logic [5:0]  in_index,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [31:0] in_pos_z,
  input  logic [31:0] in_mass,
  output logic        out_valid,
  output logic signed [63:0] out_energy,
  output logic [6:0]  out_body_count,
  output logic [1:0]  out_status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);
  import btpe_pkg::*;
`include "body_table_potential_energy_unit_defines.svh"

  localparam int AW = $clog2(MAX_BODIES);
  localparam int CW = $clog2(MAX_BODIES + 1);

  // Sequencer states.
  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_RDP   = 13'b0000000000010, // read queried body
    S_RDI   = 13'b0000000000100, // read body i
    S_DIFF  = 13'b0000000001000, // start the square of the axis difference
    S_SQ    = 13'b0000000010000, // unused
    S_SQW   = 13'b0000000100000,
    S_ROOT  = 13'b0000001000000,
    S_RTW   = 13'b0000010000000,
    S_MUL   = 13'b0000100000000, // coeff*m_p*m_i
    S_MULW  = 13'b0001000000000,
    S_DIVW  = 13'b0010000000000,
    S_NEXT  = 13'b0100000000000,
    S_MOVE  = 13'b1000000000000  // remove: copy last row
  } state_t;

  state_t      state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [31:0] coeff_r;
  logic [5:0]  shift_r;
  logic [AW-1:0] p_r, p_nxt, i_r, i_nxt, addr;
  logic [1:0]  axis_r, axis_nxt;
  logic [95:0] pos_p_r, pos_p_nxt;  // x, y, z of body p
  logic [31:0] mass_p_r, mass_p_nxt;
  logic [95:0] pos_i_r, pos_i_nxt;
  logic [31:0] mass_i_r, mass_i_nxt;
  logic [67:0] sum_r, sum_nxt;
  logic [33:0] dist_r, dist_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic        mulstep_r, mulstep_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [63:0] energy_r, energy_nxt;
  logic [1:0]  status_r, status_nxt;
  logic        we;
  logic [127:0] wdata, rdata;
  alu_ctl_t    alu_ctl;
  logic [95:0] alu_a, alu_res;
  logic [63:0] alu_b;
  logic        alu_done;
  logic signed [32:0] diff;
  logic [32:0] mag;
  logic [95:0] shifted;
  logic [63:0] term;
  logic        in_range;

  assign in_range = ((CW+6)'(in_index) < (CW+6)'(count_r));

  btpe_ram #(.WIDTH(32), .DEPTH(MAX_BODIES)) u_x (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata[31:0]), .rdata(rdata[31:0]));
  btpe_ram #(.WIDTH(32), .DEPTH(MAX_BODIES)) u_y (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata[63:32]), .rdata(rdata[63:32]));
  btpe_ram #(.WIDTH(32), .DEPTH(MAX_BODIES)) u_z (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata[95:64]), .rdata(rdata[95:64]));
  btpe_ram #(.WIDTH(32), .DEPTH(MAX_BODIES)) u_m (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata[127:96]),
    .rdata(rdata[127:96]));

  btpe_alu u_alu (
    .clk(clk), .rst_n(rst_n), .ctl(alu_ctl), .op_a(alu_a), .op_b(alu_b),
    .res(alu_res), .done(alu_done));

  // Axis difference and magnitude for the current axis.
  always_comb begin
    case (axis_r)
      2'd0:    diff = $signed({pos_p_r[31], pos_p_r[31:0]})
                      - $signed({pos_i_r[31], pos_i_r[31:0]});
      2'd1:    diff = $signed({pos_p_r[63], pos_p_r[63:32]})
                      - $signed({pos_i_r[63], pos_i_r[63:32]});
      default: diff = $signed({pos_p_r[95], pos_p_r[95:64]})
                      - $signed({pos_i_r[95], pos_i_r[95:64]});
    endcase
    mag = diff[32] ? 33'(-diff) : 33'(diff);
  end

  // Shift of the quotient and saturation of the pair term at 2^63.
  always_comb begin
    shifted = alu_res >> shift_r;
    if (shifted[95:64] != '0 || shifted[63:0] > 64'h8000_0000_0000_0000) begin
      term = 64'h8000_0000_0000_0000;
    end else begin
      term = shifted[63:0];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    p_nxt         = p_r;
    i_nxt         = i_r;
    axis_nxt      = axis_r;
    pos_p_nxt     = pos_p_r;
    mass_p_nxt    = mass_p_r;
    pos_i_nxt     = pos_i_r;
    mass_i_nxt    = mass_i_r;
    sum_nxt       = sum_r;
    dist_nxt      = dist_r;
    acc_nxt       = acc_r;
    mulstep_nxt   = mulstep_r;
    out_valid_nxt = 1'b0;
    energy_nxt    = energy_r;
    status_nxt    = status_r;
    we            = 1'b0;
    addr          = i_r;
    wdata         = {in_mass, in_pos_z, in_pos_y, in_pos_x};
    alu_ctl       = '{start: 1'b0, op: OP_MUL};
    alu_a         = '0;
    alu_b         = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          energy_nxt = '0;
          status_nxt = STATUS_OK;
          if (in_mode == MODE_APPEND) begin
            if (count_r == CW'(MAX_BODIES)) begin
              status_nxt = STATUS_FULL;
            end else begin
              we        = 1'b1;
              addr      = count_r[AW-1:0];
              count_nxt = count_r + CW'(1);
            end
            out_valid_nxt = 1'b1;
          end else if (!in_range) begin
            status_nxt    = STATUS_INDEX;
            out_valid_nxt = 1'b1;
          end else if (in_mode == MODE_OVERWRITE) begin
            we            = 1'b1;
            addr          = AW'(in_index);
            out_valid_nxt = 1'b1;
          end else if (in_mode == MODE_REMOVE) begin
            addr      = AW'(count_r - CW'(1));
            p_nxt     = AW'(in_index);
            count_nxt = count_r - CW'(1);
            state_nxt = S_MOVE;
          end else begin
            p_nxt     = AW'(in_index);
            addr      = AW'(in_index);
            acc_nxt   = '0;
            state_nxt = S_RDP;
          end
        end
      end
      S_MOVE: begin
        we            = 1'b1;
        addr          = p_r;
        wdata         = rdata;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      S_RDP: begin
        pos_p_nxt  = rdata[95:0];
        mass_p_nxt = rdata[127:96];
        i_nxt      = '0;
        addr       = '0;
        state_nxt  = S_RDI;
      end
      S_RDI: begin
        // rdata holds row i_r, addressed in the previous cycle.
        pos_i_nxt  = rdata[95:0];
        mass_i_nxt = rdata[127:96];
        axis_nxt   = 2'd0;
        sum_nxt    = '0;
        state_nxt  = (i_r == p_r) ? S_NEXT : S_DIFF;
      end
      S_DIFF: begin
        alu_ctl   = '{start: 1'b1, op: OP_MUL};
        alu_a     = 96'(mag);
        alu_b     = 64'(mag);
        state_nxt = S_SQW;
      end
      S_SQW: begin
        if (alu_done) begin
          sum_nxt = sum_r + alu_res[67:0];
          if (axis_r == 2'd2) begin
            state_nxt = S_ROOT;
          end else begin
            axis_nxt  = axis_r + 2'd1;
            state_nxt = S_DIFF;
          end
        end
      end
      S_ROOT: begin
        alu_ctl   = '{start: 1'b1, op: OP_SQRT};
        alu_a     = 96'(sum_r);
        state_nxt = S_RTW;
      end
      S_RTW: begin
        if (alu_done) begin
          dist_nxt = alu_res[33:0];
          if (alu_res[33:0] == '0) begin
            state_nxt = S_NEXT;
          end else begin
            mulstep_nxt = 1'b0;
            state_nxt   = S_MUL;
          end
        end
      end
      S_MUL: begin
        alu_ctl   = '{start: 1'b1, op: OP_MUL};
        alu_a     = mulstep_r ? alu_res : 96'(coeff_r);
        alu_b     = mulstep_r ? 64'(mass_i_r) : 64'(mass_p_r);
        state_nxt = S_MULW;
      end
      S_MULW: begin
        if (alu_done) begin
          if (!mulstep_r) begin
            mulstep_nxt = 1'b1;
            state_nxt   = S_MUL;
          end else begin
            alu_ctl   = '{start: 1'b1, op: OP_DIV};
            alu_a     = alu_res;
            alu_b     = 64'(dist_r);
            state_nxt = S_DIVW;
          end
        end
      end
      S_DIVW: begin
        if (alu_done) begin
          if (term >= 64'h8000_0000_0000_0000 - acc_r) begin
            acc_nxt = 64'h8000_0000_0000_0000;
          end else begin
            acc_nxt = acc_r + term;
          end
          state_nxt = S_NEXT;
        end
      end
      S_NEXT: begin
        if (CW'(i_r) + CW'(1) >= count_r) begin
          energy_nxt    = '0 - acc_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          i_nxt     = i_r + AW'(1);
          addr      = i_r + AW'(1);
          state_nxt = S_RDI;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      coeff_r     <= 32'd1;
      shift_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_COEFF) begin
          coeff_r <= cfg_data;
        end else begin
          shift_r <= cfg_data[5:0];
        end
      end
    end
    p_r       <= p_nxt;
    i_r       <= i_nxt;
    axis_r    <= axis_nxt;
    pos_p_r   <= pos_p_nxt;
    mass_p_r  <= mass_p_nxt;
    pos_i_r   <= pos_i_nxt;
    mass_i_r  <= mass_i_nxt;
    sum_r     <= sum_nxt;
    dist_r    <= dist_nxt;
    acc_r     <= acc_nxt;
    mulstep_r <= mulstep_nxt;
    energy_r  <= energy_nxt;
    status_r  <= status_nxt;
  end

  assign busy           = (state_r != S_IDLE);
  assign cfg_ready      = 1'b1;
  assign out_valid      = out_valid_r;
  assign out_energy     = energy_r;
  assign out_body_count = 7'(count_r);
  assign out_status     = status_r;

  `BTPE_ASSERT_NOW(a_count_max, clk, rst_n, 1'b1, count_r <= CW'(MAX_BODIES))
  `BTPE_ASSERT_NEXT(a_result_once, clk, rst_n, start && !busy, out_valid || busy)
  `BTPE_ASSERT_NOW(a_energy_only_query, clk, rst_n, out_valid && out_status != STATUS_OK,
    out_energy == '0)
  `BTPE_ASSERT_NOW(a_pos_energy_never, clk, rst_n, out_valid, !(out_energy > 0))
endmodule

>>> test/body_table_potential_energy_unit_test.sv
// Testbench for body_table_potential_energy_unit: table edits and energy queries.
// Depends on btpe_pkg and the unit's RTL; checks every result beat against a
// built-in predictor of the body table.
module body_table_potential_energy_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import btpe_pkg::*;

  localparam int TABLE_DEPTH = 64;
  localparam logic [63:0] SAT_MAG = 64'h8000_0000_0000_0000;

  typedef struct packed {
    logic [1:0]  mode;
    logic [5:0]  index;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
    logic [31:0] mass;
  } body_cmd_t;

  typedef struct packed {
    logic [63:0] energy;
    logic [6:0]  body_count;
    logic [1:0]  status;
  } body_reply_t;

  // The scoreboard keeps its own copy of the table and the registers and
  // turns every accepted command into the reply the unit must give.
  class body_energy_board;
    logic [31:0] xs[TABLE_DEPTH];
    logic [31:0] ys[TABLE_DEPTH];
    logic [31:0] zs[TABLE_DEPTH];
    logic [31:0] ms[TABLE_DEPTH];
    int unsigned bodies;
    logic [31:0] coeff;
    logic [5:0]  shift;
    body_reply_t replies_due[$];
    int errors;

    function new();
      bodies = 0;
      coeff  = 32'd1;
      shift  = 6'd0;
      errors = 0;
    endfunction

    function void set_reg(logic sel, logic [31:0] data);
      if (sel == CFG_COEFF) coeff = data;
      else shift = data[5:0];
    endfunction

    function logic [65:0] axis_sq(logic [31:0] a, logic [31:0] b);
      logic signed [32:0] diff;
      logic [32:0] mag;
      diff = $signed({a[31], a}) - $signed({b[31], b});
      mag = diff[32] ? -diff : diff;
      return {33'd0, mag} * {33'd0, mag};
    endfunction

    // Exact floor square root of the squared distance, one bit at a time.
    function logic [33:0] dist_root(logic [67:0] sq);
      logic [33:0] root;
      logic [33:0] cand;
      logic [69:0] cand_sq;
      root = '0;
      for (int b = 33; b >= 0; b--) begin
        cand = root | (34'd1 << b);
        cand_sq = {36'd0, cand} * {36'd0, cand};
        if (cand_sq <= {2'b0, sq}) root = cand;
      end
      return root;
    endfunction

    function logic [63:0] pair_mag(logic [31:0] mp, logic [31:0] mi, logic [33:0] d);
      logic [95:0] num;
      logic [95:0] quo;
      num = {64'd0, coeff} * {64'd0, mp};
      num = num * {64'd0, mi};
      quo = num / {62'd0, d};
      quo = quo >> shift;
      if (quo > {32'd0, SAT_MAG}) return SAT_MAG;
      return quo[63:0];
    endfunction

    function logic [63:0] energy_of(int p);
      logic [63:0] acc;
      logic [63:0] term;
      logic [67:0] sq;
      logic [33:0] d;
      acc = '0;
      for (int i = 0; i < bodies; i++) begin
        if (i == p) continue;
        sq = {2'b0, axis_sq(xs[p], xs[i])} + {2'b0, axis_sq(ys[p], ys[i])}
           + {2'b0, axis_sq(zs[p], zs[i])};
        d = dist_root(sq);
        // Coincident bodies contribute nothing.
        if (d == 0) continue;
        term = pair_mag(ms[p], ms[i], d);
        if (term >= SAT_MAG - acc) acc = SAT_MAG;
        else acc = acc + term;
      end
      return -acc;
    endfunction

    function void note_item(body_cmd_t c);
      body_reply_t r;
      r = '0;
      if (c.mode == MODE_APPEND) begin
        if (bodies >= TABLE_DEPTH) r.status = STATUS_FULL;
        else begin
          xs[bodies] = c.pos_x; ys[bodies] = c.pos_y;
          zs[bodies] = c.pos_z; ms[bodies] = c.mass;
          bodies++;
        end
      end else if (c.index >= bodies) begin
        r.status = STATUS_INDEX;
      end else if (c.mode == MODE_OVERWRITE) begin
        xs[c.index] = c.pos_x; ys[c.index] = c.pos_y;
        zs[c.index] = c.pos_z; ms[c.index] = c.mass;
      end else if (c.mode == MODE_REMOVE) begin
        // The last body moves into the freed slot.
        xs[c.index] = xs[bodies-1]; ys[c.index] = ys[bodies-1];
        zs[c.index] = zs[bodies-1]; ms[c.index] = ms[bodies-1];
        bodies--;
      end else begin
        r.energy = energy_of(c.index);
      end
      r.body_count = bodies[6:0];
      replies_due.insert(replies_due.size(), r);
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch: %s got %0h expected %0h at %0t", what, got, want, $time);
      errors++;
    endtask

    task check_result(body_reply_t got);
      body_reply_t want;
      if (replies_due.size() == 0) begin
        $display("unexpected result beat at %0t", $time);
        errors++;
        return;
      end
      want = replies_due.pop_front();
      if (got.energy !== want.energy) report("energy", got.energy, want.energy);
      if (got.body_count !== want.body_count)
        report("body_count", got.body_count, want.body_count);
      if (got.status !== want.status) report("status", got.status, want.status);
    endtask
  endclass

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic [1:0] in_mode;
  logic [5:0] in_index;
  logic signed [31:0] in_pos_x;
  logic signed [31:0] in_pos_y;
  logic signed [31:0] in_pos_z;
  logic [31:0] in_mass;
  logic out_valid;
  logic signed [63:0] out_energy;
  logic [6:0] out_body_count;
  logic [1:0] out_status;
  logic cfg_valid;
  logic cfg_ready;
  logic cfg_index;
  logic [31:0] cfg_data;

  body_energy_board board = new();

  body_table_potential_energy_unit u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_mode(in_mode), .in_index(in_index),
    .in_pos_x(in_pos_x), .in_pos_y(in_pos_y), .in_pos_z(in_pos_z),
    .in_mass(in_mass),
    .out_valid(out_valid), .out_energy(out_energy),
    .out_body_count(out_body_count), .out_status(out_status),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Results cannot be held off, so every strobe is checked on the edge that
  // ends its cycle.
  always @(posedge clk) begin
    if (rst_n && out_valid)
      board.check_result('{out_energy, out_body_count, out_status});
  end

  // Presents one command and holds it until an edge sees busy low. Start is
  // left high so a back-to-back beat needs no second assignment.
  task send_cmd(body_cmd_t c);
    @(negedge clk);
    start = 1'b1;
    in_mode = c.mode; in_index = c.index;
    in_pos_x = c.pos_x; in_pos_y = c.pos_y; in_pos_z = c.pos_z;
    in_mass = c.mass;
    do @(posedge clk); while (busy);
    board.note_item(c);
  endtask

  // Burst pacing: occasionally a random number of idle cycles.
  int burst_left = 0;
  task pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    burst_left = $urandom_range(0, 8);
    gap = $urandom_range(0, 6);
    if (gap > 0) begin
      @(negedge clk);
      start = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Waits until every result is back, then idles as a margin before returning.
  task drain();
    @(negedge clk);
    start = 1'b0;
    while (board.replies_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task write_reg(logic sel, logic [31:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = sel;
    cfg_data = data;
    do @(posedge clk); while (!cfg_ready);
    board.set_reg(sel, data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function logic [31:0] pick_coord();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
      default: return $urandom_range(0, 4000) - 2000;
    endcase
  endfunction

  function logic [31:0] pick_mass();
    case ($urandom_range(0, 2))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'hffff_ffff : 32'd0;
      default: return $urandom_range(1, 100000);
    endcase
  endfunction

  function body_cmd_t make_cmd(logic [1:0] mode, logic [5:0] index);
    body_cmd_t c;
    c.mode = mode; c.index = index;
    c.pos_x = pick_coord(); c.pos_y = pick_coord(); c.pos_z = pick_coord();
    c.mass = pick_mass();
    return c;
  endfunction

  // Mostly valid indices into a small table; now and then any index, and a
  // drift toward removal keeps queries short.
  function body_cmd_t random_cmd();
    logic [1:0] mode;
    logic [5:0] index;
    int r;
    r = $urandom_range(0, 99);
    if (board.bodies > 10 && r < 30) mode = MODE_REMOVE;
    else if (r < 35) mode = MODE_APPEND;
    else if (r < 55) mode = MODE_OVERWRITE;
    else if (r < 65) mode = MODE_REMOVE;
    else mode = MODE_QUERY;
    if (board.bodies == 0 || $urandom_range(0, 9) == 0) index = 6'($urandom);
    else index = 6'($urandom_range(0, board.bodies - 1));
    return make_cmd(mode, index);
  endfunction

  initial begin
    #100ms;
    $display("[body_table_potential_energy_unit] ERROR");
    $finish;
  end

  initial begin
    body_cmd_t c;
    rst_n = 1'b0;
    start = 1'b0;
    in_mode = MODE_APPEND; in_index = '0;
    in_pos_x = '0; in_pos_y = '0; in_pos_z = '0; in_mass = '0;
    cfg_valid = 1'b0; cfg_index = CFG_COEFF; cfg_data = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part at the reset register values. An empty table rejects
    // every indexed mode.
    send_cmd(make_cmd(MODE_QUERY, 6'd0));
    send_cmd(make_cmd(MODE_REMOVE, 6'd63));
    send_cmd(make_cmd(MODE_OVERWRITE, 6'd0));
    // A lone body has no partners, so its energy is zero.
    send_cmd('{MODE_APPEND, 6'd63, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
               32'hffff_ffff});
    send_cmd('{MODE_QUERY, 6'd0, 32'd0, 32'd0, 32'd0, 32'd0});
    send_cmd('{MODE_APPEND, 6'd0, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
               32'hffff_ffff});
    // A third body at the same place as the first is skipped in the sum.
    send_cmd('{MODE_APPEND, 6'd21, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
               32'd5});
    send_cmd('{MODE_APPEND, 6'd42, 32'd1, 32'd0, 32'd0, 32'hffff_ffff});
    send_cmd('{MODE_QUERY, 6'd0, 32'd0, 32'd0, 32'd0, 32'd0});
    send_cmd('{MODE_QUERY, 6'd1, 32'd0, 32'd0, 32'd0, 32'd0});
    send_cmd('{MODE_QUERY, 6'd4, 32'd0, 32'd0, 32'd0, 32'd0});
    send_cmd('{MODE_OVERWRITE, 6'd2, 32'd0, 32'd0, 32'd0, 32'hffff_ffff});
    send_cmd('{MODE_QUERY, 6'd3, 32'd0, 32'd0, 32'd0, 32'd0});
    send_cmd('{MODE_REMOVE, 6'd0, 32'd0, 32'd0, 32'd0, 32'd0});
    send_cmd('{MODE_REMOVE, 6'd3, 32'd0, 32'd0, 32'd0, 32'd0});
    send_cmd('{MODE_QUERY, 6'd2, 32'd0, 32'd0, 32'd0, 32'd0});
    drain();

    // Largest coefficient, no shift: the unit-distance pair saturates.
    write_reg(CFG_COEFF, 32'hffff_ffff);
    write_reg(CFG_SHIFT, 32'd0);
    send_cmd('{MODE_QUERY, 6'd2, 32'd0, 32'd0, 32'd0, 32'd0});
    send_cmd('{MODE_QUERY, 6'd0, 32'd0, 32'd0, 32'd0, 32'd0});
    repeat (10) begin
      send_cmd(random_cmd());
      pace();
    end
    drain();

    // Fill the table to the top, hit the full case and query at full size with
    // the widest shift, then shrink again after a new, narrower shift.
    write_reg(CFG_SHIFT, 32'd63);
    write_reg(CFG_COEFF, $urandom);
    while (board.bodies < TABLE_DEPTH) begin
      send_cmd(make_cmd(MODE_APPEND, 6'($urandom)));
      pace();
    end
    send_cmd(make_cmd(MODE_APPEND, 6'($urandom)));
    send_cmd(make_cmd(MODE_QUERY, 6'd63));
    drain();
    write_reg(CFG_SHIFT, $urandom_range(0, 40));
    send_cmd(make_cmd(MODE_QUERY, 6'($urandom)));
    while (board.bodies > 40) begin
      send_cmd(make_cmd(MODE_REMOVE, 6'($urandom_range(0, board.bodies - 1))));
      pace();
    end
    drain();

    // Random phases with fresh register values, including a zero coefficient.
    for (int ph = 0; ph < 3; ph++) begin
      write_reg(CFG_COEFF, ph == 0 ? 32'd0 : $urandom);
      write_reg(CFG_SHIFT, $urandom_range(0, 63));
      repeat (10) begin
        send_cmd(random_cmd());
        pace();
      end
      drain();
    end

    repeat (20) @(posedge clk);
    if (board.errors == 0 && board.replies_due.size() == 0) begin
      $display("[body_table_potential_energy_unit] OK");
    end else begin
      $display("[body_table_potential_energy_unit] ERROR");
    end
    $finish;
  end
endmodule

>>> filelist.f
+incdir+design
design/btpe_pkg.sv
design/btpe_ram.sv
design/btpe_alu.sv
design/body_table_potential_energy_unit.sv
test/body_table_potential_energy_unit_test.sv
